### hw/rtl/dbpf_pkg.sv
// ----------------------------------------------------------------------------
// dbpf_pkg: shared types and constants for the PCM/PWM feeder
// Store geometry, configuration indexes, pipeline stage word and sample scaler.
// ----------------------------------------------------------------------------
package dbpf_pkg;

  localparam int HALF_SIZE   = 64;
  localparam int STORE_DEPTH = 2 * HALF_SIZE;
  localparam int POS_W       = $clog2(HALF_SIZE);
  localparam int CNT_W       = POS_W + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_BYTE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN_BIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_SHIFT = 2'd3;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_FILL = 1'b1;

  localparam logic [7:0] PAIR_OFFSET = 8'd127;

  // Word held between the control stage and the output stage
  typedef struct packed {
    logic                     play;
    logic                     pair;
    logic                     add_offset;
    logic                     fill;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [7:0]               fill_byte;
    logic                     refill;
    logic signed [3:0]        volume;
  } stage_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic half,
                                                   input logic [POS_W-1:0] pos);
    logic [ADDR_W-1:0] base;
    base = half ? ADDR_W'(HALF_SIZE) : '0;
    return base + ADDR_W'(pos);
  endfunction

  // Signed shift: left for 0..7, right by magnitude 1..8 for negatives
  function automatic logic [15:0] scale_sample(input logic [7:0] v,
                                               input logic signed [3:0] sh);
    logic [15:0] wide;
    logic [3:0]  mag;
    wide = {8'h00, v};
    mag  = (~sh) + 4'd1;
    if (sh < 0) begin
      return wide >> mag;
    end else begin
      return wide << sh[2:0];
    end
  endfunction

endpackage

### hw/rtl/dbpf_ctrl.sv
// ----------------------------------------------------------------------------
// dbpf_ctrl: configuration, pointers and half flags
// Takes each word, updates playback/fill state and issues the store reads.
// ----------------------------------------------------------------------------
module dbpf_ctrl import dbpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  action,
  input  logic [7:0]            fill_byte,
  input  logic                  advance,
  output logic [ADDR_W-1:0]     rd_addr0,
  output logic [ADDR_W-1:0]     rd_addr1,
  output logic                  s_valid,
  output stage_t                s_item
);

  logic              slow_rate;
  logic              two_byte;
  logic              sixteen_bit;
  logic signed [3:0] volume_shift;

  logic             active_half, active_half_next;
  logic [POS_W-1:0] read_pos, read_pos_next;
  logic [POS_W-1:0] fill_pos, fill_pos_next;
  logic [1:0]       half_empty, half_empty_next;
  logic             skip_toggle, skip_toggle_next;

  logic             idle;
  logic [CNT_W-1:0] p0_inc, rp_sum, fill_inc;
  logic [POS_W-1:0] p1;
  logic             play, fill_ok;
  stage_t           s_item_next;

  assign idle     = ~active_half;
  assign p0_inc   = {1'b0, read_pos} + CNT_W'(1);
  assign p1       = (p0_inc < CNT_W'(HALF_SIZE)) ? p0_inc[POS_W-1:0] : '0;
  assign rd_addr0 = store_addr(active_half, read_pos);
  assign rd_addr1 = store_addr(active_half, p1);
  assign play     = !slow_rate || skip_toggle;
  assign rp_sum   = {1'b0, read_pos} + (two_byte ? CNT_W'(2) : CNT_W'(1));
  assign fill_ok  = half_empty[idle];
  assign fill_inc = {1'b0, fill_pos} + CNT_W'(1);

  always_comb begin
    active_half_next = active_half;
    read_pos_next    = read_pos;
    fill_pos_next    = fill_pos;
    half_empty_next  = half_empty;
    skip_toggle_next = skip_toggle;
    if (accept) begin
      if (action == ACT_FILL) begin
        if (fill_ok) begin
          if (fill_inc >= CNT_W'(HALF_SIZE)) begin
            fill_pos_next         = '0;
            half_empty_next[idle] = 1'b0;
          end else begin
            fill_pos_next = fill_inc[POS_W-1:0];
          end
        end
      end else begin
        if (slow_rate) begin
          skip_toggle_next = ~skip_toggle;
        end
        if (play) begin
          if (rp_sum >= CNT_W'(HALF_SIZE)) begin
            read_pos_next                = '0;
            half_empty_next[active_half] = 1'b1;
            active_half_next             = ~active_half;
            fill_pos_next                = '0;
          end else begin
            read_pos_next = rp_sum[POS_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    s_item_next.fill       = (action == ACT_FILL);
    s_item_next.play       = (action == ACT_TICK) && play;
    s_item_next.pair       = two_byte;
    s_item_next.add_offset = two_byte && sixteen_bit;
    s_item_next.wr_en      = (action == ACT_FILL) ? fill_ok
                                                  : (play && two_byte && sixteen_bit);
    s_item_next.wr_addr    = (action == ACT_FILL) ? store_addr(idle, fill_pos) : rd_addr0;
    s_item_next.fill_byte  = fill_byte;
    s_item_next.refill     = half_empty_next[~active_half_next];
    s_item_next.volume     = volume_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_rate    <= 1'b1;
      two_byte     <= 1'b0;
      sixteen_bit  <= 1'b0;
      volume_shift <= '0;
      active_half  <= 1'b0;
      read_pos     <= '0;
      fill_pos     <= '0;
      half_empty   <= 2'b11;
      skip_toggle  <= 1'b0;
      s_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLOW_RATE:    slow_rate    <= cfg_data[0];
          CFG_TWO_BYTE:     two_byte     <= cfg_data[0];
          CFG_SIXTEEN_BIT:  sixteen_bit  <= cfg_data[0];
          CFG_VOLUME_SHIFT: volume_shift <= cfg_data;
          default:          slow_rate    <= slow_rate;
        endcase
      end
      active_half <= active_half_next;
      read_pos    <= read_pos_next;
      fill_pos    <= fill_pos_next;
      half_empty  <= half_empty_next;
      skip_toggle <= skip_toggle_next;
      if (accept) begin
        s_valid <= 1'b1;
      end else if (advance) begin
        s_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_item <= s_item_next;
    end
  end

endmodule

### hw/rtl/dbpf_store.sv
// ----------------------------------------------------------------------------
// dbpf_store: two-half sample store
// One write and two registered reads per cycle; per-entry valid bits read zero.
// ----------------------------------------------------------------------------
module dbpf_store import dbpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr0,
  input  logic [ADDR_W-1:0] rd_addr1,
  input  wr_req_t           wr,
  output logic [7:0]        rd_data0,
  output logic [7:0]        rd_data1
);

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid;

  logic [7:0] raw0, raw1, fwd_data;
  logic       hit0, hit1, vld0, vld1;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      raw0 <= mem[rd_addr0];
      raw1 <= mem[rd_addr1];
    end
  end

  // Side info for each read: entry valid, and whether a same-edge write bypasses
  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld0     <= valid[rd_addr0];
      vld1     <= valid[rd_addr1];
      hit0     <= wr.en && (wr.addr == rd_addr0);
      hit1     <= wr.en && (wr.addr == rd_addr1);
      fwd_data <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  assign rd_data0 = hit0 ? fwd_data : (vld0 ? raw0 : 8'h00);
  assign rd_data1 = hit1 ? fwd_data : (vld1 ? raw1 : 8'h00);

endmodule

### hw/rtl/dbpf_out.sv
// ----------------------------------------------------------------------------
// dbpf_out: sample scaling and result register
// Forms the played bytes, writes back fills and offsets, holds the duty values.
// ----------------------------------------------------------------------------
module dbpf_out import dbpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_valid,
  input  stage_t      s_item,
  input  logic [7:0]  rd_data0,
  input  logic [7:0]  rd_data1,
  input  logic        result_stall,
  output logic        advance,
  output wr_req_t     wr,
  output logic        result_valid,
  output logic [15:0] duty_a,
  output logic [15:0] duty_b,
  output logic        duty_updated,
  output logic        refill_wanted
);

  logic [7:0] byte_a, byte_b;

  assign advance = s_valid && (!result_valid || !result_stall);
  assign byte_a  = s_item.add_offset ? (rd_data0 + PAIR_OFFSET) : rd_data0;
  assign byte_b  = s_item.pair ? rd_data1 : byte_a;

  assign wr.en   = advance && s_item.wr_en;
  assign wr.addr = s_item.wr_addr;
  assign wr.data = s_item.fill ? s_item.fill_byte : byte_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      duty_a       <= '0;
      duty_b       <= '0;
    end else if (advance) begin
      result_valid <= 1'b1;
      if (s_item.play) begin
        duty_a <= scale_sample(byte_a, s_item.volume);
        duty_b <= scale_sample(byte_b, s_item.volume);
      end
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      duty_updated  <= s_item.play;
      refill_wanted <= s_item.refill;
    end
  end

endmodule

### hw/rtl/double_buffered_pcm_pwm_feeder_top.sv
// ----------------------------------------------------------------------------
// double_buffered_pcm_pwm_feeder_top: double-buffered PCM feeder for two PWMs
// Fill words load the idle half, tick words play the active half to duty A/B.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+--------------------------------------
//  item     | item_valid / item_stall   | action, fill_byte
//  result   | result_valid/result_stall | duty_a, duty_b, duty_updated,
//           |                           | refill_wanted
//  config   | cfg_we (no wait)          | cfg_index, cfg_data
//
//  One word per cycle while result_stall is low; a taken word is registered
//  by the control stage (with the store read), and the scaling stage then
//  loads the result register from it.
//  Reset clears the pointers, flags and all 128 store valid bits at once;
//  no clearing pass, so words are taken straight after reset.
//  item_stall rises only while the scaling stage is full and the result
//  register is held by result_stall.
// ----------------------------------------------------------------------------
module double_buffered_pcm_pwm_feeder_top import dbpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // item channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  action,
  input  logic [7:0]            fill_byte,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [15:0]           duty_a,
  output logic [15:0]           duty_b,
  output logic                  duty_updated,
  output logic                  refill_wanted
);

  logic              accept, advance, s_valid;
  logic [ADDR_W-1:0] rd_addr0, rd_addr1;
  logic [7:0]        rd_data0, rd_data1;
  stage_t            s_item;
  wr_req_t           wr;

  // Stage ahead of the result register only blocks when it cannot drain
  assign item_stall = s_valid && !advance;
  assign accept     = item_valid && !item_stall;

  // State update and store read for the incoming word
  dbpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .action    (action),
    .fill_byte (fill_byte),
    .advance   (advance),
    .rd_addr0  (rd_addr0),
    .rd_addr1  (rd_addr1),
    .s_valid   (s_valid),
    .s_item    (s_item)
  );

  // Sample store; write-back from the scaling stage is bypassed to same-edge reads
  dbpf_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .wr       (wr),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  // Offset, volume shift and the result register (which is the duty state)
  dbpf_out u_out (
    .clk           (clk),
    .rst           (rst),
    .s_valid       (s_valid),
    .s_item        (s_item),
    .rd_data0      (rd_data0),
    .rd_data1      (rd_data1),
    .result_stall  (result_stall),
    .advance       (advance),
    .wr            (wr),
    .result_valid  (result_valid),
    .duty_a        (duty_a),
    .duty_b        (duty_b),
    .duty_updated  (duty_updated),
    .refill_wanted (refill_wanted)
  );

endmodule

### verif/double_buffered_pcm_pwm_feeder_top_tb.sv
// ----------------------------------------------------------------------------
// double_buffered_pcm_pwm_feeder_top_tb: self-checking bench for the PCM feeder
// A scripted opening walks the reset state, the skip toggle, an underrun, a
// half filled to the brim, dropped fill words and a swap in the middle of a fill.
// Randomised phases under different settings follow. Every result word is scored
// against its scripted answer or an in-bench model of the store and duty registers.
// ----------------------------------------------------------------------------
module double_buffered_pcm_pwm_feeder_top_tb;
  import dbpf_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int NUM_PHASES      = 8;
  localparam int WORDS_PER_PHASE = 120;
  localparam int DRAIN_CYCLES    = 6;

  // One result word as the bench expects it
  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic        updated;
    logic        refill;
  } duty_word_t;

  // Scripted row: a word repeated reps times, optionally with a fixed answer
  typedef struct packed {
    logic       act;
    logic [7:0] b;
    int         reps;
    bit         typed;
    duty_word_t want;
  } dir_row_t;

  // DUT connections; the inputs are at known values from time zero
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_SLOW_RATE;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  logic                  action       = ACT_TICK;
  logic [7:0]            fill_byte    = 8'h00;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [15:0]           duty_a;
  logic [15:0]           duty_b;
  logic                  duty_updated;
  logic                  refill_wanted;

  // Model of the feeder: store, pointers, flags, duty registers, settings
  logic [7:0]  pcm_store [0:STORE_DEPTH-1];
  logic        play_half  = 1'b0;
  int          play_pos   = 0;
  int          fill_pos   = 0;
  bit   [1:0]  half_empty = 2'b11;
  bit          skip_phase = 1'b0;
  logic [15:0] duty_a_q   = '0;
  logic [15:0] duty_b_q   = '0;
  bit          cfg_slow   = 1'b1;
  bit          cfg_pair   = 1'b0;
  bit          cfg_offset = 1'b0;
  logic [3:0]  cfg_volume = 4'h0;   // two's complement, -8..7

  duty_word_t expected_duties [$];

  int  errors        = 0;
  int  cycle_count   = 0;
  int  results_seen  = 0;
  int  fills_written = 0;
  int  fills_dropped = 0;
  int  ticks_played  = 0;
  int  ticks_skipped = 0;
  int  half_swaps    = 0;
  int  burst_left    = 1;
  bit  valid_up      = 1'b0;
  int  stall_left    = 0;
  int  stall_mode    = 0;

  // Scripted opening, run under the reset settings (slow rate, mono, no shift)
  dir_row_t dir_table [17] = '{
    // first tick is swallowed by the skip toggle; the byte on a tick is ignored
    '{ACT_TICK, 8'hA5,   1, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1}},
    // underrun: the empty active half still plays its zeroes
    '{ACT_TICK, 8'h00,   1, 1'b1, '{16'h0000, 16'h0000, 1'b1, 1'b1}},
    '{ACT_FILL, 8'hFF,   1, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1}},
    '{ACT_FILL, 8'h00,   1, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1}},
    '{ACT_FILL, 8'h80,   1, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1}},
    '{ACT_FILL, 8'h7F,   1, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1}},
    '{ACT_TICK, 8'h00,   2, 1'b0, '0},
    '{ACT_FILL, 8'h55,  59, 1'b0, '0},
    // last byte of the idle half: refill request drops
    '{ACT_FILL, 8'hAA,   1, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b0}},
    // idle half full: word dropped, nothing moves
    '{ACT_FILL, 8'h33,   1, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b0}},
    // drain the rest of half 0, ending on the swap
    '{ACT_TICK, 8'h00, 124, 1'b0, '0},
    '{ACT_TICK, 8'h00,   1, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1}},
    '{ACT_TICK, 8'h00,   1, 1'b1, '{16'h00FF, 16'h00FF, 1'b1, 1'b1}},
    // part-fill half 0, then swap under it: fill pointer must restart
    '{ACT_FILL, 8'h12,  10, 1'b0, '0},
    '{ACT_TICK, 8'h00, 126, 1'b0, '0},
    '{ACT_FILL, 8'hC3,   1, 1'b0, '0},
    '{ACT_TICK, 8'h00,   4, 1'b0, '0}
  };

  double_buffered_pcm_pwm_feeder_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .fill_byte    (fill_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .duty_a       (duty_a),
    .duty_b       (duty_b),
    .duty_updated (duty_updated),
    .refill_wanted(refill_wanted)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    foreach (pcm_store[i]) pcm_store[i] = 8'h00;
  end

  // Volume: non-negative shifts left by 0..7, negative shifts right by 1..8
  function automatic logic [15:0] apply_volume(input logic [7:0] v);
    logic [15:0] wide;
    wide = {8'h00, v};
    if (cfg_volume[3]) begin
      return wide >> (16 - cfg_volume);
    end
    return wide << cfg_volume[2:0];
  endfunction

  // Advance the model by one word and return the result word it yields
  function automatic duty_word_t step_feeder(input logic act, input logic [7:0] b,
                                             output bit dropped);
    duty_word_t w;
    logic       idle;
    bit         play;
    int         base;
    int         p0;
    int         p1;
    w       = '0;
    dropped = 1'b0;
    idle    = ~play_half;
    if (act == ACT_FILL) begin
      if (half_empty[idle]) begin
        pcm_store[(idle ? HALF_SIZE : 0) + fill_pos] = b;
        fills_written++;
        fill_pos++;
        if (fill_pos >= HALF_SIZE) begin
          fill_pos         = 0;
          half_empty[idle] = 1'b0;
        end
      end else begin
        dropped = 1'b1;
        fills_dropped++;
      end
    end else begin
      play = 1'b1;
      if (cfg_slow) begin
        skip_phase = ~skip_phase;
        if (skip_phase) play = 1'b0;
      end
      if (play) begin
        base = play_half ? HALF_SIZE : 0;
        p0   = (play_pos < HALF_SIZE) ? play_pos : 0;
        if (!cfg_pair) begin
          duty_a_q = apply_volume(pcm_store[base + p0]);
          duty_b_q = duty_a_q;
          play_pos = p0 + 1;
        end else begin
          p1 = (p0 + 1 < HALF_SIZE) ? p0 + 1 : 0;
          // offset is written back into the store, so a replay sees it again
          if (cfg_offset) pcm_store[base + p0] = pcm_store[base + p0] + PAIR_OFFSET;
          duty_a_q = apply_volume(pcm_store[base + p0]);
          duty_b_q = apply_volume(pcm_store[base + p1]);
          play_pos = p0 + 2;
        end
        w.updated = 1'b1;
        ticks_played++;
        if (play_pos >= HALF_SIZE) begin
          play_pos              = 0;
          half_empty[play_half] = 1'b1;
          play_half             = ~play_half;
          fill_pos              = 0;
          half_swaps++;
        end
      end else begin
        ticks_skipped++;
      end
    end
    w.duty_a = duty_a_q;
    w.duty_b = duty_b_q;
    w.refill = half_empty[~play_half];
    return w;
  endfunction

  // Offer one word, hold it through stalls, predict once taken, then maybe gap
  task automatic send_word(input logic act, input logic [7:0] b, input bit typed,
                           input duty_word_t want, output bit dropped);
    duty_word_t pred;
    int         gap;
    item_valid <= 1'b1;
    action     <= act;
    fill_byte  <= b;
    valid_up    = 1'b1;
    do @(posedge clk); while (item_stall);
    pred = step_feeder(act, b, dropped);
    expected_duties.push_back(typed ? want : pred);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // roughly one burst in four runs straight into the next
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        item_valid <= 1'b0;
        valid_up    = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending and wait until every expected word has come back
  task automatic drain_results();
    if (valid_up) begin
      item_valid <= 1'b0;
      valid_up    = 1'b0;
    end
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on back-to-back edges; block is idle here
  task automatic load_settings(input bit slow, input bit pair, input bit offs,
                               input int vol);
    logic [CFG_IDX_W-1:0]  regs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    regs = '{CFG_SLOW_RATE, CFG_TWO_BYTE, CFG_SIXTEEN_BIT, CFG_VOLUME_SHIFT};
    vals = '{CFG_DATA_W'(slow), CFG_DATA_W'(pair), CFG_DATA_W'(offs),
             CFG_DATA_W'(vol)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cfg_slow   = slow;
    cfg_pair   = pair;
    cfg_offset = offs;
    cfg_volume = 4'(vol);
  endtask

  // Receiver back-pressure: modes of free flow, light, heavy and periodic stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: begin
          result_stall <= 1'b0;
        end
        1: begin
          result_stall <= ($urandom_range(0, 9) < 3);
        end
        2: begin
          result_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          result_stall <= ((cycle_count % 5) < 2);
        end
      endcase
    end
  end

  // Scoreboard: each taken result word against the oldest expectation
  always @(posedge clk) begin : duty_check
    duty_word_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_duties.size() == 0) begin
        $display("%0t: unexpected result word a=%h b=%h upd=%b refill=%b",
                 $time, duty_a, duty_b, duty_updated, refill_wanted);
        errors++;
      end else begin
        want = expected_duties.pop_front();
        if (duty_a !== want.duty_a) begin
          $display("%0t: duty_a expected %h got %h", $time, want.duty_a, duty_a);
          errors++;
        end
        if (duty_b !== want.duty_b) begin
          $display("%0t: duty_b expected %h got %h", $time, want.duty_b, duty_b);
          errors++;
        end
        if (duty_updated !== want.updated) begin
          $display("%0t: duty_updated expected %b got %b", $time, want.updated,
                   duty_updated);
          errors++;
        end
        if (refill_wanted !== want.refill) begin
          $display("%0t: refill_wanted expected %b got %b", $time, want.refill,
                   refill_wanted);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d words outstanding", $time,
               expected_duties.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    bit dropped;
    int applied;
    int run;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // scripted opening under reset settings
    foreach (dir_table[r]) begin
      for (int k = 0; k < dir_table[r].reps; k++) begin
        send_word(dir_table[r].act, dir_table[r].b, dir_table[r].typed,
                  dir_table[r].want, dropped);
      end
    end

    // randomised phases; settings only change with the pipe empty
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          load_settings(1'b1, 1'b0, 1'b0, 0);
        end
        1: begin
          load_settings(1'b0, 1'b1, 1'b1, -8);   // right shift of eight zeroes all
        end
        2: begin
          load_settings(1'b0, 1'b0, 1'b0, 7);
        end
        3: begin
          load_settings(1'b1, 1'b1, 1'b0, -1);
        end
        4: begin
          load_settings(1'b0, 1'b1, 1'b1, 7);
        end
        default: begin
          load_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), int'($urandom_range(0, 15)) - 8);
        end
      endcase
      applied = 0;
      while (applied < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 2) begin
          // noise: mixed fill and tick words
          run = $urandom_range(1, 12);
          repeat (run) begin
            send_word($urandom_range(0, 1) ? ACT_FILL : ACT_TICK,
                      8'($urandom_range(0, 255)), 1'b0, '0, dropped);
            if (!dropped) applied++;
          end
        end else begin
          // playback pattern: top up the idle half, then play for a while
          run = $urandom_range(HALF_SIZE / 2, HALF_SIZE + 6);
          repeat (run) begin
            send_word(ACT_FILL, 8'($urandom_range(0, 255)), 1'b0, '0, dropped);
            if (!dropped) applied++;
          end
          run = $urandom_range(8, 140);
          repeat (run) begin
            send_word(ACT_TICK, 8'($urandom_range(0, 255)), 1'b0, '0, dropped);
            applied++;
          end
        end
      end
    end
    drain_results();

    $display("Checked %0d result words over %0d setting phases, %0d half swaps.",
             results_seen, NUM_PHASES, half_swaps);
    $display("Fills stored %0d, dropped %0d; ticks played %0d, skipped %0d.",
             fills_written, fills_dropped, ticks_played, ticks_skipped);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
